[rtl/scac_pkg.sv]
// ----------------------------------------------------------------------------
// Sector cache aging replacement package
// Shared codes, widths and constants for the tag and policy engine.
// ----------------------------------------------------------------------------
`default_nettype none

package scac_pkg;

   localparam int OPCODE_W   = 2;
   localparam int OWNER_W    = 16;
   localparam int SECTOR_W   = 32;
   localparam int TICK_W     = 32;
   localparam int PERIOD_W   = 16;
   localparam int KIND_W     = 2;
   localparam int SLOT_OUT_W = 5;
   localparam int CSR_IDX_W  = 2;

   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NOP   = 2'd3;

   localparam logic [KIND_W-1:0] KIND_ACCESS    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITEBACK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK_DONE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_AGING_PERIOD     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITEBACK_PERIOD = 2'd1;

   localparam logic [PERIOD_W-1:0] AGING_PERIOD_RESET     = 16'd64;
   localparam logic [PERIOD_W-1:0] WRITEBACK_PERIOD_RESET = 16'd1024;

endpackage

`default_nettype wire

[rtl/scac_rem.sv]
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring division of the tick number by a period, one bit per cycle,
// reporting whether the remainder is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module scac_rem
   import scac_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [TICK_W-1:0]   dividend,
   input  wire logic [PERIOD_W-1:0] divisor,
   output logic                     done,
   output logic                     rem_zero
);

   localparam int CNT_W = $clog2(TICK_W);

   logic [TICK_W-1:0]   dvd_ff, dvd_in;
   logic [PERIOD_W-1:0] dvs_ff, dvs_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [PERIOD_W:0]   trial;

   always_comb begin
      trial   = {rem_ff, dvd_ff[TICK_W-1]};
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[TICK_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = PERIOD_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[PERIOD_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(TICK_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

`default_nettype wire

[rtl/sector_cache_aging_replacement.sv]
// ----------------------------------------------------------------------------
// Sector cache aging replacement
// Tag and policy engine of a fully associative write-back sector cache.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Reads and writes
// look up (owner, sector) by walking the slots one per cycle, then insert
// on a miss; a tick ages the entries and flushes dirty slots when the tick
// number is a multiple of the respective period.
// Each result appears for one cycle with rsp_valid high; rsp_last marks the
// final result of an item. The receiver cannot stall.
// An access ends on a hit during the slot walk, or with the fill after it.
// A tick runs two 32-step remainder computations in the shared remainder
// unit, then a walk over all slots for each aging or flush that is due,
// then the final marker.
// Opcode 3 is accepted and ignored.
// Reset empties the cache and loads the period registers with 64 and 1024.
// The csr channel is ready only while idle and no item is being started.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_cache_aging_replacement
   import scac_pkg::*;
#(
   parameter int NUM_SLOTS = 32,
   parameter int AGE_BITS  = 8
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [OPCODE_W-1:0]   req_opcode,
   input  wire logic [OWNER_W-1:0]    req_owner_id,
   input  wire logic [SECTOR_W-1:0]   req_sector,
   input  wire logic [TICK_W-1:0]     req_tick_count,
   output logic                       rsp_valid,
   output logic [KIND_W-1:0]          rsp_kind,
   output logic                       rsp_hit,
   output logic [SLOT_OUT_W-1:0]      rsp_slot,
   output logic                       rsp_victim_valid,
   output logic                       rsp_victim_dirty,
   output logic [SECTOR_W-1:0]        rsp_out_sector,
   output logic                       rsp_last,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [PERIOD_W-1:0]   csr_wdata
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [AGE_BITS-1:0] AGE_TOP = AGE_BITS'(1) << (AGE_BITS - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_FILL   = 4'd2;
   localparam logic [3:0] S_DIV_AG = 4'd3;
   localparam logic [3:0] S_DIV_WB = 4'd4;
   localparam logic [3:0] S_AGE    = 4'd5;
   localparam logic [3:0] S_WB     = 4'd6;
   localparam logic [3:0] S_DONE   = 4'd7;

   logic [3:0]           state_ff, state_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [PERIOD_W-1:0]  aging_period_ff, aging_period_in;
   logic [PERIOD_W-1:0]  wb_period_ff, wb_period_in;
   logic                 is_write_ff, is_write_in;
   logic [OWNER_W-1:0]   owner_ff, owner_in;
   logic [SECTOR_W-1:0]  sector_ff, sector_in;
   logic [TICK_W-1:0]    ticks_ff, ticks_in;
   logic                 free_found_ff, free_found_in;
   logic [SLOT_W-1:0]    free_idx_ff, free_idx_in;
   logic [SLOT_W-1:0]    best_idx_ff, best_idx_in;
   logic [AGE_BITS-1:0]  best_age_ff, best_age_in;
   logic                 best_dirty_ff, best_dirty_in;
   logic [SECTOR_W-1:0]  best_sector_ff, best_sector_in;
   logic                 ag_hit_ff, ag_hit_in;
   logic                 wb_hit_ff, wb_hit_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [NUM_SLOTS-1:0] acc_ff, acc_in;
   logic [NUM_SLOTS-1:0] dirty_ff, dirty_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                 rsp_vv_ff, rsp_vv_in;
   logic                 rsp_vd_ff, rsp_vd_in;
   logic [SECTOR_W-1:0]  rsp_sector_ff, rsp_sector_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [OWNER_W-1:0]   owner_mem_ff  [NUM_SLOTS];
   logic [SECTOR_W-1:0]  sector_mem_ff [NUM_SLOTS];
   logic [AGE_BITS-1:0]  age_mem_ff    [NUM_SLOTS];

   logic                 ins_we;
   logic [SLOT_W-1:0]    ins_idx;
   logic                 age_we;
   logic [SLOT_W-1:0]    age_widx;
   logic [AGE_BITS-1:0]  age_wdata;

   logic                 div_start;
   logic [TICK_W-1:0]    div_dividend;
   logic [PERIOD_W-1:0]  div_divisor;
   logic                 div_done;
   logic                 div_zero;

   logic [OWNER_W-1:0]   rd_owner;
   logic [SECTOR_W-1:0]  rd_sector;
   logic [AGE_BITS-1:0]  rd_age;
   logic [SLOT_W-1:0]    fill_idx;
   logic                 wb_now;

   scac_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .rem_zero (div_zero)
   );

   assign rd_owner  = owner_mem_ff[idx_ff];
   assign rd_sector = sector_mem_ff[idx_ff];
   assign rd_age    = age_mem_ff[idx_ff];
   assign fill_idx  = free_found_ff ? free_idx_ff : best_idx_ff;

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      aging_period_in = aging_period_ff;
      wb_period_in    = wb_period_ff;
      is_write_in     = is_write_ff;
      owner_in        = owner_ff;
      sector_in       = sector_ff;
      ticks_in        = ticks_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      best_idx_in     = best_idx_ff;
      best_age_in     = best_age_ff;
      best_dirty_in   = best_dirty_ff;
      best_sector_in  = best_sector_ff;
      ag_hit_in       = ag_hit_ff;
      wb_hit_in       = wb_hit_ff;
      valid_in        = valid_ff;
      acc_in          = acc_ff;
      dirty_in        = dirty_ff;
      rsp_valid_in    = 1'b0;
      rsp_kind_in     = KIND_ACCESS;
      rsp_hit_in      = 1'b0;
      rsp_slot_in     = '0;
      rsp_vv_in       = 1'b0;
      rsp_vd_in       = 1'b0;
      rsp_sector_in   = '0;
      rsp_last_in     = 1'b0;
      ins_we          = 1'b0;
      ins_idx         = fill_idx;
      age_we          = 1'b0;
      age_widx        = idx_ff;
      age_wdata       = '0;
      div_start       = 1'b0;
      div_dividend    = ticks_ff;
      div_divisor     = wb_period_ff;
      wb_now          = 1'b0;

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_AGING_PERIOD) begin
            aging_period_in = csr_wdata;
         end else if (csr_index == CSR_WRITEBACK_PERIOD) begin
            wb_period_in = csr_wdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               is_write_in   = (req_opcode == OP_WRITE);
               owner_in      = req_owner_id;
               sector_in     = req_sector;
               ticks_in      = req_tick_count;
               idx_in        = '0;
               free_found_in = 1'b0;
               case (req_opcode)
                  OP_READ, OP_WRITE: begin
                     state_in = S_SCAN;
                  end
                  OP_TICK: begin
                     div_start    = 1'b1;
                     div_dividend = req_tick_count;
                     div_divisor  = aging_period_ff;
                     state_in     = S_DIV_AG;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (valid_ff[idx_ff] && rd_owner == owner_ff && rd_sector == sector_ff) begin
               acc_in[idx_ff] = 1'b1;
               if (is_write_ff) begin
                  dirty_in[idx_ff] = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               rsp_slot_in  = SLOT_OUT_W'(idx_ff);
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end else begin
               if (!valid_ff[idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (valid_ff[idx_ff] && (idx_ff == '0 || rd_age < best_age_ff)) begin
                  best_idx_in    = idx_ff;
                  best_age_in    = rd_age;
                  best_dirty_in  = dirty_ff[idx_ff];
                  best_sector_in = rd_sector;
               end
               if (idx_ff == LAST_SLOT) begin
                  state_in = S_FILL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_FILL: begin
            ins_we             = 1'b1;
            age_we             = 1'b1;
            age_widx           = fill_idx;
            valid_in[fill_idx] = 1'b1;
            acc_in[fill_idx]   = 1'b1;
            dirty_in[fill_idx] = is_write_ff;
            rsp_valid_in       = 1'b1;
            rsp_slot_in        = SLOT_OUT_W'(fill_idx);
            rsp_vv_in          = !free_found_ff;
            rsp_vd_in          = !free_found_ff && best_dirty_ff;
            rsp_sector_in      = free_found_ff ? '0 : best_sector_ff;
            rsp_last_in        = 1'b1;
            state_in           = S_IDLE;
         end
         S_DIV_AG: begin
            if (div_done) begin
               ag_hit_in = div_zero && (aging_period_ff != '0);
               div_start = 1'b1;
               state_in  = S_DIV_WB;
            end
         end
         S_DIV_WB: begin
            if (div_done) begin
               wb_now    = div_zero && (wb_period_ff != '0);
               wb_hit_in = wb_now;
               idx_in    = '0;
               if (ag_hit_ff) begin
                  state_in = S_AGE;
               end else if (wb_now) begin
                  state_in = S_WB;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_AGE: begin
            if (valid_ff[idx_ff]) begin
               age_we         = 1'b1;
               age_wdata      = (rd_age >> 1) | (acc_ff[idx_ff] ? AGE_TOP : '0);
               acc_in[idx_ff] = 1'b0;
            end
            if (idx_ff == LAST_SLOT) begin
               idx_in   = '0;
               state_in = wb_hit_ff ? S_WB : S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_WB: begin
            if (valid_ff[idx_ff] && dirty_ff[idx_ff]) begin
               dirty_in[idx_ff] = 1'b0;
               rsp_valid_in     = 1'b1;
               rsp_kind_in      = KIND_WRITEBACK;
               rsp_slot_in      = SLOT_OUT_W'(idx_ff);
               rsp_sector_in    = rd_sector;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_TICK_DONE;
            rsp_last_in  = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         aging_period_ff <= AGING_PERIOD_RESET;
         wb_period_ff    <= WRITEBACK_PERIOD_RESET;
         valid_ff        <= '0;
         acc_ff          <= '0;
         dirty_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         aging_period_ff <= aging_period_in;
         wb_period_ff    <= wb_period_in;
         valid_ff        <= valid_in;
         acc_ff          <= acc_in;
         dirty_ff        <= dirty_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      is_write_ff    <= is_write_in;
      owner_ff       <= owner_in;
      sector_ff      <= sector_in;
      ticks_ff       <= ticks_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      best_idx_ff    <= best_idx_in;
      best_age_ff    <= best_age_in;
      best_dirty_ff  <= best_dirty_in;
      best_sector_ff <= best_sector_in;
      ag_hit_ff      <= ag_hit_in;
      wb_hit_ff      <= wb_hit_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_vv_ff      <= rsp_vv_in;
      rsp_vd_ff      <= rsp_vd_in;
      rsp_sector_ff  <= rsp_sector_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (ins_we) begin
         owner_mem_ff[ins_idx]  <= owner_ff;
         sector_mem_ff[ins_idx] <= sector_ff;
      end
      if (age_we) begin
         age_mem_ff[age_widx] <= age_wdata;
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = (state_ff == S_IDLE) && !start;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_victim_valid = rsp_vv_ff;
   assign rsp_victim_dirty = rsp_vd_ff;
   assign rsp_out_sector   = rsp_sector_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/scac_checker.sv]
// ----------------------------------------------------------------------------
// Sector cache aging replacement checker
// Port-level assertions on item flow and result framing.
// ----------------------------------------------------------------------------
`default_nettype none

module scac_checker
   import scac_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic [OPCODE_W-1:0]   req_opcode,
   input wire logic                  rsp_valid,
   input wire logic [KIND_W-1:0]     rsp_kind,
   input wire logic                  rsp_hit,
   input wire logic                  rsp_victim_valid,
   input wire logic                  rsp_last
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode != OP_NOP) |=> busy)
      else $error("busy did not rise after an item was accepted");

   a_access_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ACCESS) |-> rsp_last)
      else $error("access reply not marked last");

   a_tick_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_TICK_DONE) |-> (rsp_last && !rsp_hit))
      else $error("tick done result malformed");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("block idle before the last result of an item");

   a_hit_no_victim: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_victim_valid)
      else $error("hit reported an eviction");

endmodule

bind sector_cache_aging_replacement scac_checker u_scac_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_opcode       (req_opcode),
   .rsp_valid        (rsp_valid),
   .rsp_kind         (rsp_kind),
   .rsp_hit          (rsp_hit),
   .rsp_victim_valid (rsp_victim_valid),
   .rsp_last         (rsp_last)
);

`default_nettype wire

[tb/sv/sector_cache_aging_replacement_checker.sv]
// ----------------------------------------------------------------------------
// Sector cache aging replacement checker
// Watches the item, result and register channels of the tag engine, keeps
// its own copy of the tags, ages and marks, and compares every result
// against the oldest expected one.
// ----------------------------------------------------------------------------
module sector_cache_aging_replacement_checker
   import scac_pkg::*;
#(
   parameter int NUM_SLOTS = 32,
   parameter int AGE_BITS  = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [OWNER_W-1:0]    req_owner_id,
   input  logic [SECTOR_W-1:0]   req_sector,
   input  logic [TICK_W-1:0]     req_tick_count,
   input  logic                  rsp_valid,
   input  logic [KIND_W-1:0]     rsp_kind,
   input  logic                  rsp_hit,
   input  logic [SLOT_OUT_W-1:0] rsp_slot,
   input  logic                  rsp_victim_valid,
   input  logic                  rsp_victim_dirty,
   input  logic [SECTOR_W-1:0]   rsp_out_sector,
   input  logic                  rsp_last,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [PERIOD_W-1:0]   csr_wdata,
   output int                    errors,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  victim_valid;
      logic                  victim_dirty;
      logic [SECTOR_W-1:0]   out_sector;
      logic                  last;
   } cache_rsp_t;

   cache_rsp_t          expected_rsps[$];
   logic [PERIOD_W-1:0] aging_period;
   logic [PERIOD_W-1:0] flush_period;
   logic                slot_valid [NUM_SLOTS];
   logic [OWNER_W-1:0]  slot_owner [NUM_SLOTS];
   logic [SECTOR_W-1:0] slot_sector [NUM_SLOTS];
   logic [AGE_BITS-1:0] slot_age [NUM_SLOTS];
   logic                slot_accessed [NUM_SLOTS];
   logic                slot_dirty [NUM_SLOTS];

   function automatic cache_rsp_t make_rsp(logic [KIND_W-1:0] kind, logic hit, int slot,
                                           logic vv, logic vd, logic [SECTOR_W-1:0] sec,
                                           logic last);
      cache_rsp_t r;
      r.kind = kind;
      r.hit = hit;
      r.slot = slot[SLOT_OUT_W-1:0];
      r.victim_valid = vv;
      r.victim_dirty = vd;
      r.out_sector = sec;
      r.last = last;
      return r;
   endfunction

   task automatic lookup_and_fill(logic is_write, logic [OWNER_W-1:0] owner,
                                  logic [SECTOR_W-1:0] sec);
      int found;
      int victim;
      found = -1;
      victim = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (found < 0 && slot_valid[i] && slot_owner[i] == owner && slot_sector[i] == sec)
            found = i;
      end
      if (found >= 0) begin
         slot_accessed[found] = 1'b1;
         if (is_write)
            slot_dirty[found] = 1'b1;
         expected_rsps.push_back(make_rsp(KIND_ACCESS, 1'b1, found, 1'b0, 1'b0, '0, 1'b1));
      end else begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (victim < 0 && !slot_valid[i])
               victim = i;
         end
         if (victim >= 0) begin
            expected_rsps.push_back(make_rsp(KIND_ACCESS, 1'b0, victim, 1'b0, 1'b0, '0, 1'b1));
         end else begin
            victim = 0;
            for (int i = 1; i < NUM_SLOTS; i++) begin
               if (slot_age[i] < slot_age[victim])
                  victim = i;
            end
            expected_rsps.push_back(make_rsp(KIND_ACCESS, 1'b0, victim, 1'b1,
                                             slot_dirty[victim], slot_sector[victim], 1'b1));
         end
         slot_valid[victim] = 1'b1;
         slot_owner[victim] = owner;
         slot_sector[victim] = sec;
         slot_age[victim] = '0;
         slot_accessed[victim] = 1'b1;
         slot_dirty[victim] = is_write;
      end
   endtask

   task automatic age_and_flush(logic [TICK_W-1:0] tick_count);
      if (aging_period != 0 && tick_count % 32'(aging_period) == 0) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_valid[i]) begin
               slot_age[i] = {slot_accessed[i], slot_age[i][AGE_BITS-1:1]};
               slot_accessed[i] = 1'b0;
            end
         end
      end
      if (flush_period != 0 && tick_count % 32'(flush_period) == 0) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_valid[i] && slot_dirty[i]) begin
               expected_rsps.push_back(make_rsp(KIND_WRITEBACK, 1'b0, i, 1'b0, 1'b0,
                                                slot_sector[i], 1'b0));
               slot_dirty[i] = 1'b0;
            end
         end
      end
      expected_rsps.push_back(make_rsp(KIND_TICK_DONE, 1'b0, 0, 1'b0, 1'b0, '0, 1'b1));
   endtask

   always @(posedge clock) begin
      cache_rsp_t seen;
      cache_rsp_t want;
      if (reset) begin
         expected_rsps.delete();
         aging_period = AGING_PERIOD_RESET;
         flush_period = WRITEBACK_PERIOD_RESET;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_accessed[i] = 1'b0;
            slot_dirty[i] = 1'b0;
         end
         errors <= 0;
      end else begin
         if (rsp_valid) begin
            seen = make_rsp(rsp_kind, rsp_hit, int'(rsp_slot), rsp_victim_valid,
                            rsp_victim_dirty, rsp_out_sector, rsp_last);
            if (expected_rsps.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected result kind=%0d slot=%0d sector=%h",
                           $realtime, rsp_kind, rsp_slot, rsp_out_sector);
               errors <= errors + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (seen !== want) begin
                  if (errors < 10)
                     $display({"%0t: result mismatch expected kind=%0d hit=%b slot=%0d ",
                               "vv=%b vd=%b sector=%h last=%b, got kind=%0d hit=%b ",
                               "slot=%0d vv=%b vd=%b sector=%h last=%b"}, $realtime,
                              want.kind, want.hit, want.slot, want.victim_valid,
                              want.victim_dirty, want.out_sector, want.last,
                              seen.kind, seen.hit, seen.slot, seen.victim_valid,
                              seen.victim_dirty, seen.out_sector, seen.last);
                  errors <= errors + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_AGING_PERIOD)
               aging_period = csr_wdata;
            else if (csr_index == CSR_WRITEBACK_PERIOD)
               flush_period = csr_wdata;
         end
         if (start && !busy) begin
            if (req_opcode == OP_READ || req_opcode == OP_WRITE)
               lookup_and_fill(req_opcode == OP_WRITE, req_owner_id, req_sector);
            else if (req_opcode == OP_TICK)
               age_and_flush(req_tick_count);
         end
      end
      pending <= expected_rsps.size();
   end

endmodule

[tb/sv/sector_cache_aging_replacement_tb.sv]
// ----------------------------------------------------------------------------
// Sector cache aging replacement testbench
// Drives directed and random accesses and ticks with random gaps under
// several period settings; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module sector_cache_aging_replacement_tb;
   import scac_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 300;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [OPCODE_W-1:0]   req_opcode;
   logic [OWNER_W-1:0]    req_owner_id;
   logic [SECTOR_W-1:0]   req_sector;
   logic [TICK_W-1:0]     req_tick_count;
   logic                  rsp_valid;
   logic [KIND_W-1:0]     rsp_kind;
   logic                  rsp_hit;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic                  rsp_victim_valid;
   logic                  rsp_victim_dirty;
   logic [SECTOR_W-1:0]   rsp_out_sector;
   logic                  rsp_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [PERIOD_W-1:0]   csr_wdata;
   int                    errors;
   int                    pending;
   int                    idle_cycles;
   logic                  no_gaps;
   logic [PERIOD_W-1:0]   cur_aging;
   logic [PERIOD_W-1:0]   cur_flush;
   logic [OWNER_W-1:0]    hot_owners [6];
   logic [SECTOR_W-1:0]   hot_base;

   sector_cache_aging_replacement dut (.*);

   sector_cache_aging_replacement_checker checker_i (.*);

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("sector_cache_aging_replacement test failed");
         $finish;
      end
   end

   task automatic send_item(logic [OPCODE_W-1:0] op, logic [OWNER_W-1:0] owner,
                            logic [SECTOR_W-1:0] sec, logic [TICK_W-1:0] ticks);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_owner_id <= owner;
      req_sector <= sec;
      req_tick_count <= ticks;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [PERIOD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_periods(logic [PERIOD_W-1:0] ap, logic [PERIOD_W-1:0] wp);
      write_csr(CSR_AGING_PERIOD, ap);
      write_csr(CSR_WRITEBACK_PERIOD, wp);
      cur_aging = ap;
      cur_flush = wp;
   endtask

   task automatic random_items(int count);
      logic [OPCODE_W-1:0] op;
      logic [OWNER_W-1:0]  owner;
      logic [SECTOR_W-1:0] sec;
      logic [TICK_W-1:0]   ticks;
      int                  pick;
      for (int n = 0; n < count; n++) begin
         if (n % 20 == 0)
            no_gaps = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         op = (pick < 10) ? OP_TICK : (pick < 12) ? OP_NOP :
              ($urandom_range(0, 1) ? OP_WRITE : OP_READ);
         if ($urandom_range(0, 4) != 0) begin
            owner = hot_owners[$urandom_range(0, 5)];
            sec = hot_base + $urandom_range(0, 7);
         end else begin
            owner = $urandom;
            sec = $urandom;
         end
         pick = $urandom_range(0, 9);
         if (pick < 6)
            ticks = cur_aging * $urandom_range(0, 65535);
         else if (pick < 8)
            ticks = cur_flush * $urandom_range(0, 65535);
         else
            ticks = $urandom;
         send_item(op, owner, sec, ticks);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_READ;
      req_owner_id = '0;
      req_sector = '0;
      req_tick_count = '0;
      csr_valid = 1'b0;
      csr_index = CSR_AGING_PERIOD;
      csr_wdata = '0;
      no_gaps = 1'b0;
      cur_aging = AGING_PERIOD_RESET;
      cur_flush = WRITEBACK_PERIOD_RESET;
      for (int i = 0; i < 6; i++)
         hot_owners[i] = $urandom;
      hot_base = $urandom;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_READ, 16'h0000, 32'h0000_0000, 32'h0);
      send_item(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
      send_item(OP_WRITE, 16'h0000, 32'h0000_0000, 32'h0);
      send_item(OP_READ, 16'hFFFF, 32'h0000_0000, 32'h0);
      send_item(OP_NOP, 16'h1234, 32'h5678_9ABC, 32'h0);
      send_item(OP_TICK, 16'h0, 32'h0, 32'd5);
      send_item(OP_TICK, 16'h0, 32'h0, 32'd64);
      send_item(OP_TICK, 16'h0, 32'h0, 32'd0);
      send_item(OP_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);
      send_item(OP_WRITE, 16'h0000, 32'h0000_0000, 32'h0);
      send_item(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'd1024);
      random_items(60);
      drain();

      set_periods(16'd1, 16'd1);
      random_items(60);
      drain();
      set_periods(16'hFFFF, 16'hFFFF);
      random_items(60);
      drain();
      set_periods(16'd2, 16'd3);
      random_items(60);
      drain();
      set_periods(16'd1, 16'hFFFF);
      random_items(60);
      drain();
      set_periods(16'd4, 16'd7);
      random_items(60);
      drain();

      if (errors == 0)
         $display("sector_cache_aging_replacement test passed");
      else
         $display("sector_cache_aging_replacement test failed");
      $finish;
   end

endmodule
